[hdl/u16u8_pkg.sv]
package u16u8_pkg;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK            = 2'd0,
		ST_OVERFLOW      = 2'd1,
		ST_STRAY_LOW     = 2'd2,
		ST_UNPAIRED_HIGH = 2'd3
	} status_t;

	localparam int UNIT_W  = 16;
	localparam int BYTE_W  = 8;
	localparam int SIZE_W  = 16;
	localparam int HIGH_W  = 10;
	localparam int MAX_OUT = 4;
	localparam int CNT_W   = 3;

	localparam logic [SIZE_W-1:0] BUFFER_SIZE_RST = 16'd256;

	// Leading and continuation byte marks.
	localparam logic [BYTE_W-1:0] LEAD_2 = 8'hC0;
	localparam logic [BYTE_W-1:0] LEAD_3 = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD_4 = 8'hF0;
	localparam logic [BYTE_W-1:0] CONT   = 8'h80;

	// Top six bits of high and low surrogates.
	localparam logic [5:0] HIGH_TAG = 6'b110110;
	localparam logic [5:0] LOW_TAG  = 6'b110111;

	localparam logic [20:0] PLANE_1 = 21'h10000;

endpackage

[hdl/u16u8_if.sv]
// Input channel: one UTF-16 code unit per transfer.
interface u16u8_in_if import u16u8_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [UNIT_W-1:0] code_unit;

	modport source (output valid, output code_unit, input ready);
	modport sink (input valid, input code_unit, output ready);
endinterface

// Output channel: one UTF-8 byte or status result per transfer.
interface u16u8_out_if import u16u8_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              last_of_run;
	status_t           status;
	logic              string_end;

	modport source (output valid, output out_byte, output last_of_run, output status,
		output string_end, input ready);
	modport sink (input valid, input out_byte, input last_of_run, input status,
		input string_end, output ready);
endinterface

// Configuration channel: writes the buffer size register.
interface u16u8_cfg_if import u16u8_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [SIZE_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[hdl/utf16_to_utf8_encoder.sv]
// UTF-16 to UTF-8 encoder. Code units enter on unit_ch, one per transfer, and UTF-8 bytes
// leave on byte_ch, one per transfer; a zero unit ends the string with a zero terminator
// flagged by string_end unless an error came first. Each unit is held in an input register,
// encoded in a single combinational pass and loaded into a four-byte result register, which
// drains one byte per cycle while byte_ch is ready; a unit gives one to four bytes (none
// for a high surrogate or a dropped unit), so the output port sets the rate. The first byte
// is offered once the unit has passed the input register and loaded the result register.
// Errors (overflow of buffer_size, stray low surrogate, unpaired high surrogate) give one
// result with byte zero, after which units are dropped until the terminating zero. The user
// must write buffer_size on cfg_ch only while the block is idle; the block does not enforce it.
module utf16_to_utf8_encoder import u16u8_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	u16u8_in_if.sink    unit_ch,
	u16u8_out_if.source byte_ch,
	u16u8_cfg_if.sink   cfg_ch
);

	// Configuration and string state.
	logic [SIZE_W-1:0] buffer_size_q;
	logic [SIZE_W-1:0] bytes_written_q;
	logic [HIGH_W-1:0] pending_high_q;
	logic              pending_valid_q;
	logic              failed_q;

	// Input register.
	logic              valid_s1;
	logic [UNIT_W-1:0] unit_s1;

	// Result register, shifted out one byte per transfer.
	logic [BYTE_W-1:0] obyte_q [MAX_OUT];
	logic [CNT_W-1:0]  cnt_q;
	status_t           status_q;
	logic              end_q;

	// Encoder outputs.
	logic [BYTE_W-1:0] nbyte_c [MAX_OUT];
	logic [CNT_W-1:0]  n_c;
	status_t           nstatus_c;
	logic              nend_c;
	logic [SIZE_W-1:0] bw_next_c;
	logic [HIGH_W-1:0] ph_next_c;
	logic              pv_next_c;
	logic              failed_next_c;

	logic              is_low;
	logic              is_high;
	logic [SIZE_W-1:0] cap;
	logic [SIZE_W:0]   bw_ext;
	logic              fits1;
	logic              fits2;
	logic              fits3;
	logic              fits4;
	logic [20:0]       cp;
	logic              out_take;
	logic              buf_free;
	logic              consume_s1;

	assign is_low  = (unit_s1[15:10] == LOW_TAG);
	assign is_high = (unit_s1[15:10] == HIGH_TAG);

	// Room check against buffer_size less the terminator.
	assign cap    = (buffer_size_q == '0) ? '0 : buffer_size_q - 1'b1;
	assign bw_ext = {1'b0, bytes_written_q};
	assign fits1  = (bw_ext + 17'd1) <= {1'b0, cap};
	assign fits2  = (bw_ext + 17'd2) <= {1'b0, cap};
	assign fits3  = (bw_ext + 17'd3) <= {1'b0, cap};
	assign fits4  = (bw_ext + 17'd4) <= {1'b0, cap};

	// Code point of a surrogate pair.
	assign cp = {1'b0, pending_high_q, unit_s1[9:0]} + PLANE_1;

	// Encode the unit in the input register.
	always_comb begin
		for (int k = 0; k < MAX_OUT; k++) begin
			nbyte_c[k] = '0;
		end
		n_c           = '0;
		nstatus_c     = ST_OK;
		nend_c        = 1'b0;
		bw_next_c     = bytes_written_q;
		ph_next_c     = pending_high_q;
		pv_next_c     = pending_valid_q;
		failed_next_c = failed_q;
		if (unit_s1 == '0) begin
			bw_next_c     = '0;
			ph_next_c     = '0;
			pv_next_c     = 1'b0;
			failed_next_c = 1'b0;
			if (!failed_q) begin
				n_c = CNT_W'(1);
				if (pending_valid_q) begin
					nstatus_c = ST_UNPAIRED_HIGH;
				end else begin
					nend_c = 1'b1;
				end
			end
		end else if (!failed_q) begin
			if (pending_valid_q) begin
				ph_next_c = '0;
				pv_next_c = 1'b0;
				n_c       = CNT_W'(1);
				if (!is_low) begin
					nstatus_c     = ST_UNPAIRED_HIGH;
					failed_next_c = 1'b1;
				end else if (!fits4) begin
					nstatus_c     = ST_OVERFLOW;
					failed_next_c = 1'b1;
				end else begin
					n_c        = CNT_W'(4);
					nbyte_c[0] = LEAD_4 | {5'd0, cp[20:18]};
					nbyte_c[1] = CONT | {2'd0, cp[17:12]};
					nbyte_c[2] = CONT | {2'd0, cp[11:6]};
					nbyte_c[3] = CONT | {2'd0, cp[5:0]};
					bw_next_c  = bytes_written_q + SIZE_W'(4);
				end
			end else if (unit_s1 < 16'h0080) begin
				n_c = CNT_W'(1);
				if (!fits1) begin
					nstatus_c     = ST_OVERFLOW;
					failed_next_c = 1'b1;
				end else begin
					nbyte_c[0] = {1'b0, unit_s1[6:0]};
					bw_next_c  = bytes_written_q + SIZE_W'(1);
				end
			end else if (unit_s1 < 16'h0800) begin
				if (!fits2) begin
					n_c           = CNT_W'(1);
					nstatus_c     = ST_OVERFLOW;
					failed_next_c = 1'b1;
				end else begin
					n_c        = CNT_W'(2);
					nbyte_c[0] = LEAD_2 | {3'd0, unit_s1[10:6]};
					nbyte_c[1] = CONT | {2'd0, unit_s1[5:0]};
					bw_next_c  = bytes_written_q + SIZE_W'(2);
				end
			end else if (is_high) begin
				if (!fits4) begin
					n_c           = CNT_W'(1);
					nstatus_c     = ST_OVERFLOW;
					failed_next_c = 1'b1;
				end else begin
					ph_next_c = unit_s1[9:0];
					pv_next_c = 1'b1;
				end
			end else if (is_low) begin
				n_c           = CNT_W'(1);
				nstatus_c     = ST_STRAY_LOW;
				failed_next_c = 1'b1;
			end else if (!fits3) begin
				n_c           = CNT_W'(1);
				nstatus_c     = ST_OVERFLOW;
				failed_next_c = 1'b1;
			end else begin
				n_c        = CNT_W'(3);
				nbyte_c[0] = LEAD_3 | {4'd0, unit_s1[15:12]};
				nbyte_c[1] = CONT | {2'd0, unit_s1[11:6]};
				nbyte_c[2] = CONT | {2'd0, unit_s1[5:0]};
				bw_next_c  = bytes_written_q + SIZE_W'(3);
			end
		end
	end

	// Handshake: a unit leaves the input register once its results can be loaded.
	assign out_take   = byte_ch.valid & byte_ch.ready;
	assign buf_free   = (cnt_q == '0) || ((cnt_q == CNT_W'(1)) && byte_ch.ready);
	assign consume_s1 = valid_s1 && ((n_c == '0) || buf_free);
	assign unit_ch.ready = !valid_s1 || consume_s1;
	assign cfg_ch.ready  = 1'b1;

	// Output port.
	assign byte_ch.valid       = (cnt_q != '0);
	assign byte_ch.out_byte    = obyte_q[0];
	assign byte_ch.last_of_run = (cnt_q == CNT_W'(1));
	assign byte_ch.status      = status_q;
	assign byte_ch.string_end  = end_q;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (unit_ch.valid && unit_ch.ready) begin
			valid_s1 <= 1'b1;
		end else if (consume_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (unit_ch.valid && unit_ch.ready) begin
			unit_s1 <= unit_ch.code_unit;
		end
	end

	// Configuration and string state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_size_q   <= BUFFER_SIZE_RST;
			bytes_written_q <= '0;
			pending_high_q  <= '0;
			pending_valid_q <= 1'b0;
			failed_q        <= 1'b0;
		end else begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				buffer_size_q <= cfg_ch.data;
			end
			if (consume_s1) begin
				bytes_written_q <= bw_next_c;
				pending_high_q  <= ph_next_c;
				pending_valid_q <= pv_next_c;
				failed_q        <= failed_next_c;
			end
		end
	end

	// Result count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (consume_s1 && (n_c != '0)) begin
			cnt_q <= n_c;
		end else if (out_take) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Result bytes and tags.
	always_ff @(posedge clk) begin
		if (consume_s1 && (n_c != '0)) begin
			for (int k = 0; k < MAX_OUT; k++) begin
				obyte_q[k] <= nbyte_c[k];
			end
			status_q <= nstatus_c;
			end_q    <= nend_c;
		end else if (out_take) begin
			for (int k = 0; k < MAX_OUT - 1; k++) begin
				obyte_q[k] <= obyte_q[k+1];
			end
			obyte_q[MAX_OUT-1] <= '0;
		end
	end

endmodule

[hdl/u16u8_checker.sv]
module u16u8_checker import u16u8_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input logic [BYTE_W-1:0] out_byte,
	input logic              last_of_run,
	input status_t           status,
	input logic              string_end
);

	// A stalled result holds its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte)
			&& $stable(last_of_run) && $stable(status) && $stable(string_end))
		else $error("result changed while stalled");

	// Error results are single, zero and not a terminator.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> last_of_run && (out_byte == '0) && !string_end)
		else $error("malformed error result");

	// The terminator is a lone zero byte with good status.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && string_end |-> last_of_run && (out_byte == '0) && (status == ST_OK))
		else $error("malformed terminator");

	// The bytes of one unit follow each other without a gap.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_run |=> out_valid)
		else $error("gap inside a multi-byte sequence");

	// A multi-byte sequence continues with continuation bytes.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_run |=> out_byte[7:6] == 2'b10)
		else $error("missing continuation byte");

endmodule

bind utf16_to_utf8_encoder u16u8_checker u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (byte_ch.valid),
	.out_ready   (byte_ch.ready),
	.out_byte    (byte_ch.out_byte),
	.last_of_run (byte_ch.last_of_run),
	.status      (byte_ch.status),
	.string_end  (byte_ch.string_end)
);
